@@ sv/cshit_pkg.sv @@
package cshit_pkg;

  // angle accumulator holds 2^ZW per turn
  localparam int ZW = 32;
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;
  // cordic datapath width, enough for scaled coordinates plus gain
  localparam int CW = 34;
  // coordinates are scaled up to this many bits before cordic
  localparam int FRAC = 30;
  // radicand and root widths of the square root pipeline
  localparam int NW = 2 * FRAC;
  localparam int RW = FRAC;
  localparam int MAX_STEPS = 24;
  localparam int Q_DEPTH = 4;

  typedef enum logic [1:0] {
    CLS_MISS,
    CLS_HIT,
    CLS_TEST
  } cls_t;

  function automatic logic [ZW-1:0] atan_step(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051E;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2F;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2F9;
      15: v = 32'h0000_517C;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A2F;
      19: v = 32'h0000_0517;
      20: v = 32'h0000_028B;
      21: v = 32'h0000_0145;
      22: v = 32'h0000_00A2;
      23: v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // width of one queue entry: class, dx, dy, circle radius, d2 - r2, direction, width
  function automatic int q_width(input int c, input int a);
    return 2 + 2 * (c + 1) + (c - 1) + 2 * c + 2 * a;
  endfunction

endpackage

@@ sv/cshit_queue.sv @@
module cshit_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int PW = $clog2(cshit_pkg::Q_DEPTH);

  logic [W-1:0] mem [cshit_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  logic push;
  logic pop;

  assign in_ready = count != (PW+1)'(cshit_pkg::Q_DEPTH);
  assign out_valid = count != '0;
  assign out_data = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(cshit_pkg::Q_DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not follow a pop");
`endif

endmodule

@@ sv/cshit_front.sv @@
module cshit_front #(
  parameter int C = 16,
  parameter int A = 16,
  localparam int DW = ((6 * C - 2 + 2 * A + 7) / 8) * 8,
  localparam int QW = cshit_pkg::q_width(C, A)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_data,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [QW-1:0] q_data
);

  typedef struct packed {
    cshit_pkg::cls_t   cls;
    logic signed [C:0] dx;
    logic signed [C:0] dy;
    logic [C-2:0]      cr;
    logic [2*C-1:0]    diff;
    logic [A-1:0]      dir;
    logic [A-1:0]      wid;
  } item_t;

  logic signed [C-1:0] cx, cy, sx, sy;
  logic [C-2:0] cr_in, sr_in;

  assign cx = in_data[C-1:0];
  assign cy = in_data[2*C-1:C];
  assign cr_in = in_data[3*C-2:2*C];
  assign sx = in_data[4*C-2:3*C-1];
  assign sy = in_data[5*C-2:4*C-1];
  assign sr_in = in_data[6*C-3:5*C-1];

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3 || q_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: differences and radius sum
  logic signed [C:0] dx1, dy1;
  logic [C-2:0] cr1;
  logic [C-1:0] sum1;
  logic [A-1:0] dir1, wid1;

  // stage 2: squares
  logic signed [2*C+1:0] dxsq, dysq;
  logic [2*C-1:0] sumsq, crsq;
  logic signed [C:0] dx2, dy2_c;
  logic [2*C-1:0] dxx2, dyy2, sum2, cr2;
  logic [C-2:0] crr2;
  logic [A-1:0] dir2, wid2;

  assign dxsq = dx1 * dx1;
  assign dysq = dy1 * dy1;
  assign sumsq = (2*C)'(sum1) * (2*C)'(sum1);
  assign crsq = (2*C)'(cr1) * (2*C)'(cr1);

  // stage 3: classify
  logic [2*C:0] d2;
  item_t s3_next, s3;

  assign d2 = {1'b0, dxx2} + {1'b0, dyy2};

  always_comb begin
    s3_next.dx = dx2;
    s3_next.dy = dy2_c;
    s3_next.cr = crr2;
    s3_next.diff = d2[2*C-1:0] - cr2;
    s3_next.dir = dir2;
    s3_next.wid = wid2;
    if (d2 > {1'b0, sum2}) begin
      s3_next.cls = cshit_pkg::CLS_MISS;
    end else if (d2 < {1'b0, cr2} || d2 == '0) begin
      s3_next.cls = cshit_pkg::CLS_HIT;
    end else begin
      s3_next.cls = cshit_pkg::CLS_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx1 <= {cx[C-1], cx} - {sx[C-1], sx};
      dy1 <= {cy[C-1], cy} - {sy[C-1], sy};
      cr1 <= cr_in;
      sum1 <= {1'b0, cr_in} + {1'b0, sr_in};
      dir1 <= in_data[6*C-3+A:6*C-2];
      wid1 <= in_data[6*C-3+2*A:6*C-2+A];
    end
    if (rdy2 && v1) begin
      dxx2 <= dxsq[2*C-1:0];
      dyy2 <= dysq[2*C-1:0];
      sum2 <= sumsq;
      cr2 <= crsq;
      dx2 <= dx1;
      dy2_c <= dy1;
      crr2 <= cr1;
      dir2 <= dir1;
      wid2 <= wid1;
    end
    if (rdy3 && v2) begin
      s3 <= s3_next;
    end
  end

  assign q_valid = v3;
  assign q_data = s3;

endmodule

@@ sv/cshit_isqrt.sv @@
module cshit_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cshit_pkg::NW-1:0]   n,
  output logic [cshit_pkg::RW-1:0]   root
);

  localparam int NW = cshit_pkg::NW;
  localparam int RW = cshit_pkg::RW;

  logic [NW-1:0] rem [RW+1];
  logic [NW-1:0] acc [RW+1];

  assign rem[0] = n;
  assign acc[0] = '0;

  // one result bit per stage, restoring method
  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
    logic [NW:0] trial;

    assign trial = {1'b0, acc[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1] <= rem[k] - trial[NW-1:0];
          acc[k+1] <= (acc[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          acc[k+1] <= acc[k] >> 1;
        end
      end
    end
  end

  assign root = acc[RW][RW-1:0];

endmodule

@@ sv/cshit_cordic.sv @@
module cshit_cordic #(
  parameter int A = 16,
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [cshit_pkg::CW-1:0] x_in,
  input  logic signed [cshit_pkg::CW-1:0] y_in,
  output logic [A-1:0]                    angle
);

  localparam int CW = cshit_pkg::CW;
  localparam int ZW = cshit_pkg::ZW;
  localparam int N = (STEPS < cshit_pkg::MAX_STEPS) ? STEPS : cshit_pkg::MAX_STEPS;
  localparam logic [ZW:0] RND = (ZW+1)'(1) << (ZW - 1 - A);

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic [ZW-1:0] zs [N+1];
  logic [ZW:0] zr;

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= cshit_pkg::HALF_TURN;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [ZW-1:0] ATN = cshit_pkg::atan_step(i);

    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATN;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATN;
        end
      end
    end
  end

  // round half up to the output angle width
  assign zr = {1'b0, zs[N]} + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zr[ZW-A +: A];
    end
  end

endmodule

@@ sv/cshit_back.sv @@
module cshit_back #(
  parameter int C = 16,
  parameter int A = 16,
  parameter int STEPS = 16,
  localparam int QW = cshit_pkg::q_width(C, A)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_hit
);

  localparam int CW = cshit_pkg::CW;
  localparam int RW = cshit_pkg::RW;
  localparam int P = cshit_pkg::FRAC - C;
  localparam int N = (STEPS < cshit_pkg::MAX_STEPS) ? STEPS : cshit_pkg::MAX_STEPS;
  localparam int CL = N + 2;
  localparam int DL = RW + CL;

  typedef struct packed {
    cshit_pkg::cls_t   cls;
    logic signed [C:0] dx;
    logic signed [C:0] dy;
    logic [C-2:0]      cr;
    logic [2*C-1:0]    diff;
    logic [A-1:0]      dir;
    logic [A-1:0]      wid;
  } item_t;

  typedef struct packed {
    logic              valid;
    cshit_pkg::cls_t   cls;
    logic signed [C:0] dx;
    logic signed [C:0] dy;
    logic [C-2:0]      cr;
    logic [A-1:0]      dir;
    logic [A-1:0]      wid;
  } side_t;

  item_t q_item;
  side_t sd [DL+1];
  logic [cshit_pkg::NW-1:0] p0_n;
  logic [RW-1:0] root;
  logic be;

  assign q_item = q_data;
  // the whole back pipeline moves together when the output register is free
  assign be = !out_valid || out_ready;
  assign q_ready = be;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (be) begin
      sd[0].valid <= q_valid;
      sd[0].cls <= q_item.cls;
      sd[0].dx <= q_item.dx;
      sd[0].dy <= q_item.dy;
      sd[0].cr <= q_item.cr;
      sd[0].dir <= q_item.dir;
      sd[0].wid <= q_item.wid;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      p0_n <= {q_item.diff, {(2*P){1'b0}}};
    end
  end

  for (genvar k = 1; k <= DL; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k].valid <= 1'b0;
      end else if (be) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  cshit_isqrt u_isqrt (
    .clk (clk),
    .en  (be),
    .n   (p0_n),
    .root(root)
  );

  logic signed [CW-1:0] bx, by, hx, hy;
  logic [A-1:0] bearing, half;

  // bearing uses atan2(-dy, dx), half width uses atan2(r, sqrt(d2 - r2))
  assign bx = CW'(sd[RW].dx) <<< P;
  assign by = -(CW'(sd[RW].dy) <<< P);
  assign hx = CW'(root);
  assign hy = CW'(sd[RW].cr) <<< P;

  cshit_cordic #(.A(A), .STEPS(STEPS)) u_bearing (
    .clk  (clk),
    .en   (be),
    .x_in (bx),
    .y_in (by),
    .angle(bearing)
  );

  cshit_cordic #(.A(A), .STEPS(STEPS)) u_half (
    .clk  (clk),
    .en   (be),
    .x_in (hx),
    .y_in (hy),
    .angle(half)
  );

  logic [A-1:0] delta;
  logic [A:0] back_d, diffm;
  logic [A+1:0] lhs, rhs;
  logic hit_next;

  assign delta = bearing - sd[DL].dir;
  assign back_d = {1'b1, {A{1'b0}}} - {1'b0, delta};
  assign diffm = ({1'b0, delta} < back_d) ? {1'b0, delta} : back_d;
  assign lhs = {diffm, 1'b0};
  assign rhs = (A+2)'(sd[DL].wid) + {1'b0, half, 1'b0};

  always_comb begin
    case (sd[DL].cls)
      cshit_pkg::CLS_MISS: hit_next = 1'b0;
      cshit_pkg::CLS_HIT:  hit_next = 1'b1;
      cshit_pkg::CLS_TEST: hit_next = lhs < rhs;
      default:             hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (be) begin
      out_valid <= sd[DL].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_hit <= hit_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss: assert property (@(posedge clk) disable iff (rst)
    be && sd[DL].valid && sd[DL].cls == cshit_pkg::CLS_MISS |=> out_valid && !out_hit)
    else $error("miss class gave a hit");
  a_near: assert property (@(posedge clk) disable iff (rst)
    be && sd[DL].valid && sd[DL].cls == cshit_pkg::CLS_HIT |=> out_valid && out_hit)
    else $error("hit class gave a miss");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !be |=> $stable(sd[DL].valid) && $stable(sd[0].valid))
    else $error("back pipeline moved while stalled");
`endif

endmodule

@@ sv/circle_sector_hit_test.sv @@
// channel   dir  tdata fields, lowest bit first
// s_axis    in   circle_x, circle_y, circle_radius, sector_x, sector_y,
//                sector_radius, sector_direction, sector_width, zero fill
// m_axis    out  hit, zero fill
//
// one transaction per cycle in and out while m_axis_tready stays high; the
// unrolled cordic and the one-bit-per-stage square root pipeline sit in the
// back pipeline behind the queue
// rst is synchronous and clears valid state only
// a stalled output freezes the back pipeline; the front keeps filling a
// four-entry queue and stalls s_axis only when it is full
module circle_sector_hit_test #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int DW = ((6 * COORD_BITS - 2 + 2 * ANGLE_BITS + 7) / 8) * 8,
  localparam int QW = cshit_pkg::q_width(COORD_BITS, ANGLE_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // circle_x, circle_y, circle_radius, sector_x, sector_y, sector_radius,
  // sector_direction, sector_width
  input  logic [DW-1:0] s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // hit
  output logic [7:0]    m_axis_tdata
);

  logic fq_valid, fq_ready;
  logic [QW-1:0] fq_data;
  logic bq_valid, bq_ready;
  logic [QW-1:0] bq_data;
  logic hit;

  cshit_front #(.C(COORD_BITS), .A(ANGLE_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_data (s_axis_tdata),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  cshit_queue #(.W(QW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_data  (fq_data),
    .out_valid(bq_valid),
    .out_ready(bq_ready),
    .out_data (bq_data)
  );

  cshit_back #(.C(COORD_BITS), .A(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_data   (bq_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_hit  (hit)
  );

  assign m_axis_tdata = {{7{1'b0}}, hit};

endmodule

@@ tb/sv/circle_sector_hit_test_test.sv @@
`timescale 1ns / 1ps

module circle_sector_hit_test_test;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0] cr;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [14:0] sr;
    logic [15:0] dir;
    logic [15:0] wid;
  } probe_t;

  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [7:0] m_axis_tdata;

  probe_t pending_probes[$];
  logic hit_expected[$];
  probe_t probe_on_bus;
  logic in_fired;
  int in_gap;
  int out_gap;
  int mismatches;
  int cycles;

  circle_sector_hit_test dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] arctan_step(input int i);
    logic [31:0] t [16];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
          32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
    return t[i];
  endfunction

  // vectoring rotation, result as a 16-bit binary angle
  function automatic logic [15:0] vector_angle(input longint x, input longint y);
    logic [31:0] z;
    longint xs;
    longint ys;
    logic [63:0] rounded;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_step(i);
      end
    end
    rounded = {32'b0, z} + 64'h8000;
    return rounded[31:16];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic sector_touches(input probe_t p);
    longint dx;
    longint dy;
    longint d2;
    longint sum;
    longint cr2;
    logic [15:0] bearing;
    logic [15:0] half;
    logic [15:0] delta;
    longint back;
    longint diff;
    logic [63:0] root;
    dx = longint'(p.cx) - longint'(p.sx);
    dy = longint'(p.cy) - longint'(p.sy);
    d2 = dx * dx + dy * dy;
    sum = longint'(p.cr) + longint'(p.sr);
    cr2 = longint'(p.cr) * longint'(p.cr);
    if (d2 > sum * sum) return 1'b0;
    if (d2 < cr2 || d2 == 0) return 1'b1;
    bearing = vector_angle(dx * 16384, -dy * 16384);
    root = floor_root(64'(d2 - cr2) << 28);
    half = vector_angle(longint'(root), longint'(p.cr) * 16384);
    delta = bearing - p.dir;
    back = 65536 - longint'(delta);
    diff = (longint'(delta) < back) ? longint'(delta) : back;
    return (2 * diff < longint'(p.wid) + 2 * longint'(half));
  endfunction

  function automatic logic [127:0] pack_probe(input probe_t p);
    return {2'b00, p.wid, p.dir, p.sr, p.sy, p.sx, p.cr, p.cy, p.cx};
  endfunction

  function automatic probe_t make_probe(input int cx, input int cy, input int cr,
                                        input int sx, input int sy, input int sr,
                                        input int dir, input int wid);
    probe_t p;
    p.cx = cx[15:0];
    p.cy = cy[15:0];
    p.cr = cr[14:0];
    p.sx = sx[15:0];
    p.sy = sy[15:0];
    p.sr = sr[14:0];
    p.dir = dir[15:0];
    p.wid = wid[15:0];
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input driver, holds the transaction until the monitor saw it accepted
  always @(negedge clk) begin
    logic next_valid;
    next_valid = s_axis_tvalid && !in_fired;
    if (!rst && !next_valid) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
      end else if (pending_probes.size() > 0) begin
        probe_on_bus = pending_probes.pop_front();
        s_axis_tdata <= pack_probe(probe_on_bus);
        next_valid = 1'b1;
        in_gap = pick_gap();
      end
    end
    s_axis_tvalid <= next_valid;
  end

  // output stalls
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    logic want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    in_fired = !rst && s_axis_tvalid && s_axis_tready;
    if (in_fired)
      hit_expected.push_back(sector_touches(probe_on_bus));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hit_expected.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected transaction, hit=%0b", m_axis_tdata[0]);
      end else begin
        want = hit_expected.pop_front();
        if (m_axis_tdata[0] !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("hit mismatch: expected %0b got %0b", want, m_axis_tdata[0]);
        end
      end
    end
  end

  initial begin
    int sx;
    int sy;
    int cr;
    int sr;
    int reach;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    in_fired = 1'b0;
    in_gap = 0;
    out_gap = 0;
    mismatches = 0;
    cycles = 0;

    // zero distance, with and without radii
    pending_probes.push_back(make_probe(5, 5, 0, 5, 5, 0, 0, 0));
    pending_probes.push_back(make_probe(-32768, 32767, 32767, -32768, 32767, 32767, 65535, 65535));
    // circle radius zero, point on the sector axis and off it
    pending_probes.push_back(make_probe(100, 0, 0, 0, 0, 200, 0, 1000));
    pending_probes.push_back(make_probe(0, -100, 0, 0, 0, 200, 0, 1000));
    pending_probes.push_back(make_probe(0, -100, 0, 0, 0, 200, 16384, 10));
    // distance equal to circle radius
    pending_probes.push_back(make_probe(300, 0, 300, 0, 0, 10, 32768, 0));
    pending_probes.push_back(make_probe(0, 300, 300, 0, 0, 0, 16384, 0));
    // width just under a full turn, and zero width
    pending_probes.push_back(make_probe(1000, 1000, 5, 0, 0, 2000, 32768, 65535));
    pending_probes.push_back(make_probe(-1000, 1000, 5, 0, 0, 2000, 0, 0));
    // far apart, extreme coordinates
    pending_probes.push_back(make_probe(32767, 32767, 32767, -32768, -32768, 32767, 0, 65535));
    pending_probes.push_back(make_probe(-32768, -32768, 0, 32767, 32767, 0, 65535, 0));
    pending_probes.push_back(make_probe(32767, -32768, 32767, -32768, 32767, 32767, 57344, 65535));
    pending_probes.push_back(make_probe(-32768, 0, 32767, 32767, 0, 32767, 32768, 100));
    // just inside and outside the reach
    pending_probes.push_back(make_probe(1000, 0, 0, 0, 0, 1000, 0, 2));
    pending_probes.push_back(make_probe(1001, 0, 0, 0, 0, 1000, 0, 2));
    pending_probes.push_back(make_probe(600, 800, 10, 0, 0, 990, 55000, 30000));

    for (int n = 0; n < 1950; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_probes.push_back(make_probe($urandom, $urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom, $urandom));
      end else begin
        // near pairs that reach the angular test
        cr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
        sr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
        reach = cr + sr + 1;
        if (reach > 32767) reach = 32767;
        sx = $urandom;
        sy = $urandom;
        pending_probes.push_back(make_probe(sx + $urandom_range(0, 2 * reach) - reach,
                                            sy + $urandom_range(0, 2 * reach) - reach,
                                            cr, sx, sy, sr, $urandom,
                                            $urandom_range(0, 1) ? $urandom_range(0, 16384)
                                                                 : $urandom));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_probes.size() == 0);
    @(posedge clk);
    while (s_axis_tvalid || hit_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && hit_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
